// ===== rtl/sfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sawtooth formant synthesiser package
// Shared widths, register indexes, pipeline structures and the mix weights.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int NUM_FORMANTS_DEFAULT = 3;
   localparam int SAMPLE_BITS_DEFAULT  = 16;

   localparam int          PHASE_W               = 32;
   localparam logic [31:0] PHASE_INCREMENT_RESET = 32'd85704562;

   localparam int               CSR_INDEX_W         = 2;
   localparam int               CSR_DATA_W          = 54;
   localparam logic [1:0]       CSR_PHASE_INCREMENT = 2'd0;
   localparam logic [1:0]       CSR_FORMANT_BASE    = 2'd1;

   localparam int COEF_W      = 18;
   localparam int COEF_PACK_W = 54;
   localparam int B0_LSB      = 0;
   localparam int A1_LSB      = 18;
   localparam int A2_LSB      = 36;

   localparam int                 SAMPLE_W   = 24;
   localparam logic signed [23:0] SAW_OFFSET = 24'sd4194304;
   localparam int                 DX_W       = 25;
   localparam int                 PB_W       = 43;
   localparam int                 PA_W       = 42;
   localparam int                 ACC_W      = 46;
   localparam int                 FRAC_SHIFT = 16;
   localparam int                 YFULL_W    = ACC_W - FRAC_SHIFT;

   localparam int SLOT_W      = 3;
   localparam int WEIGHT_W    = 18;
   localparam int MIX_W       = 42;
   localparam int TRUNC_SHIFT = 38;
   localparam int PCM_W       = 16;
   localparam int PCM_EXT_W   = 32;
   localparam int RSP_DEPTH   = 2;

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic [SLOT_W-1:0]          slot;
      logic signed [SAMPLE_W-1:0] y0;
   } ystream_type;

   typedef struct packed {
      logic signed [PCM_W-1:0] pcm_sample;
      logic                    clipped;
   } pcm_type;

   typedef struct packed {
      logic    valid;
      pcm_type data;
   } mix_out_type;

   function automatic logic signed [WEIGHT_W-1:0] mix_weight(input logic [SLOT_W-1:0] slot);
      logic signed [WEIGHT_W-1:0] w;
      case (slot)
         3'd0: w = 18'sd65536;
         3'd1: w = 18'sd39322;
         3'd2: w = 18'sd19661;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/sawtooth_formant_synth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sawtooth formant synthesiser
// Sawtooth oscillator driving a bank of band-pass filters whose outputs are
// mixed into one saturated PCM sample per request transaction.
// ----------------------------------------------------------------------------
// A new request is taken only after the previous one has finished its
// read-modify-write loop through the filter history memory. Up to two
// responses may wait at the output; while two transactions are outstanding,
// no new request is taken. Reset clears phase, histories, coefficients and
// queue and loads the default phase increment; no start-up sweep.
// ----------------------------------------------------------------------------
module sawtooth_formant_synth #(
   parameter int NUM_FORMANTS = sfs_pkg::NUM_FORMANTS_DEFAULT,
   parameter int SAMPLE_BITS  = sfs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_clear_history,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sfs_pkg::PCM_W-1:0]    rsp_pcm_sample,
   output logic                                rsp_clipped,
   input  logic                                csr_write_enable,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int CntW = $clog2(sfs_pkg::RSP_DEPTH + 1);

   logic [sfs_pkg::PHASE_W-1:0]         phase_ff, phase_in, inc_ff;
   logic signed [sfs_pkg::SAMPLE_W-1:0] x0, x2_eff, x1_ff, x2_ff;
   logic signed [sfs_pkg::DX_W-1:0]     dx_ff, dx_in;
   logic [CntW-1:0]                     pending_ff, pending_in;
   logic                                accept, deliver, eng_idle;
   sfs_pkg::ystream_type                ystream;
   sfs_pkg::mix_out_type                mix_out;
   sfs_pkg::pcm_type                    rsp_data;

   always_comb begin
      req_ready  = eng_idle && (pending_ff < CntW'(sfs_pkg::RSP_DEPTH));
      accept     = req_valid && req_ready;
      deliver    = rsp_valid && rsp_ready;
      x0         = $signed({1'b0, phase_ff[sfs_pkg::PHASE_W-1:sfs_pkg::PHASE_W-sfs_pkg::SAMPLE_W+1]})
                   - sfs_pkg::SAW_OFFSET;
      x2_eff     = req_clear_history ? '0 : x2_ff;
      dx_in      = sfs_pkg::DX_W'(x0) - sfs_pkg::DX_W'(x2_eff);
      phase_in   = phase_ff + inc_ff;
      pending_in = pending_ff + CntW'(accept) - CntW'(deliver);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         inc_ff     <= sfs_pkg::PHASE_INCREMENT_RESET;
         x1_ff      <= '0;
         x2_ff      <= '0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (csr_write_enable && (csr_index == sfs_pkg::CSR_PHASE_INCREMENT)) begin
            inc_ff <= csr_write_data[sfs_pkg::PHASE_W-1:0];
         end
         if (accept) begin
            phase_ff <= phase_in;
            x1_ff    <= x0;
            x2_ff    <= req_clear_history ? '0 : x1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff <= dx_in;
      end
   end

   sfs_formant_engine #(
      .NUM_FORMANTS(NUM_FORMANTS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (accept),
      .clear_history    (req_clear_history),
      .dx               (dx_ff),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .idle             (eng_idle),
      .ystream          (ystream)
   );

   sfs_mixer #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mixer (
      .clock   (clock),
      .reset   (reset),
      .ystream (ystream),
      .mix_out (mix_out)
   );

   sfs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mix_out),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_data)
   );

   always_comb begin
      rsp_pcm_sample = rsp_data.pcm_sample;
      rsp_clipped    = rsp_data.clipped;
   end

   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CntW'(sfs_pkg::RSP_DEPTH))
      else $error("more transactions outstanding than the response queue holds");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while the filter history update is still running");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid || mix_out.valid) |-> (pending_ff != '0))
      else $error("response produced with no request outstanding");

endmodule

// ===== rtl/sfs_formant_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formant engine
// Steps through the band-pass filters one per cycle, reading, updating and
// writing back each filter's output history in a synchronous memory.
// ----------------------------------------------------------------------------
module sfs_formant_engine #(
   parameter int NUM_FORMANTS = sfs_pkg::NUM_FORMANTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                clear_history,
   input  logic signed [sfs_pkg::DX_W-1:0]     dx,
   input  logic                                csr_write_enable,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                idle,
   output sfs_pkg::ystream_type                ystream
);

   localparam int IdxW = (NUM_FORMANTS > 1) ? $clog2(NUM_FORMANTS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FORMANTS - 1);
   localparam int HistW = 2 * sfs_pkg::SAMPLE_W;
   localparam logic signed [sfs_pkg::ACC_W-1:0] RoundHalf =
      sfs_pkg::ACC_W'(1 << (sfs_pkg::FRAC_SHIFT - 1));
   localparam logic signed [sfs_pkg::YFULL_W-1:0] YMax =
      sfs_pkg::YFULL_W'((1 << (sfs_pkg::SAMPLE_W - 1)) - 1);
   localparam logic signed [sfs_pkg::YFULL_W-1:0] YMin =
      sfs_pkg::YFULL_W'(-(1 << (sfs_pkg::SAMPLE_W - 1)));

   logic [sfs_pkg::COEF_PACK_W-1:0] coef_ff [NUM_FORMANTS];
   logic [HistW-1:0]                hist_mem [NUM_FORMANTS];
   logic [NUM_FORMANTS-1:0]         hist_vld_ff, hist_vld_in;

   logic            busy_ff, busy_in;
   logic [IdxW-1:0] k_ff, k_in;

   logic                            s1_v_ff, s1_first_ff, s1_last_ff;
   logic [IdxW-1:0]                 s1_k_ff;
   logic [sfs_pkg::COEF_PACK_W-1:0] s1_coef_ff;
   logic [HistW-1:0]                rd_data_ff;
   logic                            rd_vld_ff;

   logic signed [sfs_pkg::COEF_W-1:0]   b0, a1, a2;
   logic signed [sfs_pkg::SAMPLE_W-1:0] y1, y2;
   logic signed [sfs_pkg::PB_W-1:0]     pb_in, pb_ff;
   logic signed [sfs_pkg::PA_W-1:0]     pa1_in, pa1_ff, pa2_in, pa2_ff;

   logic                                s2_v_ff, s2_first_ff, s2_last_ff;
   logic [IdxW-1:0]                     s2_k_ff;
   logic signed [sfs_pkg::SAMPLE_W-1:0] s2_y1_ff;
   logic signed [sfs_pkg::ACC_W-1:0]    acc;
   logic signed [sfs_pkg::YFULL_W-1:0]  yfull;
   logic signed [sfs_pkg::SAMPLE_W-1:0] y0_in;

   logic                                y_vld_ff, y_first_ff, y_last_ff;
   logic [sfs_pkg::SLOT_W-1:0]          y_slot_ff;
   logic signed [sfs_pkg::SAMPLE_W-1:0] y0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_FORMANTS; k++) begin
            coef_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_FORMANTS; k++) begin
            if (csr_write_enable &&
                (4'(csr_index) == 4'(sfs_pkg::CSR_FORMANT_BASE) + 4'(k))) begin
               coef_ff[k] <= csr_write_data;
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (busy_ff) begin
         k_in = k_ff + IdxW'(1);
         if (k_ff == LastIdx) begin
            busy_in = 1'b0;
            k_in    = '0;
         end
      end
   end

   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (start && clear_history) begin
         hist_vld_in = '0;
      end else if (s2_v_ff) begin
         hist_vld_in[s2_k_ff] = 1'b1;
      end
   end

   always_comb begin
      b0     = s1_coef_ff[sfs_pkg::B0_LSB +: sfs_pkg::COEF_W];
      a1     = s1_coef_ff[sfs_pkg::A1_LSB +: sfs_pkg::COEF_W];
      a2     = s1_coef_ff[sfs_pkg::A2_LSB +: sfs_pkg::COEF_W];
      y1     = rd_vld_ff ? rd_data_ff[sfs_pkg::SAMPLE_W-1:0] : '0;
      y2     = rd_vld_ff ? rd_data_ff[HistW-1:sfs_pkg::SAMPLE_W] : '0;
      pb_in  = sfs_pkg::PB_W'(b0) * sfs_pkg::PB_W'(dx);
      pa1_in = sfs_pkg::PA_W'(a1) * sfs_pkg::PA_W'(y1);
      pa2_in = sfs_pkg::PA_W'(a2) * sfs_pkg::PA_W'(y2);
   end

   always_comb begin
      acc = sfs_pkg::ACC_W'(pb_ff) - sfs_pkg::ACC_W'(pa1_ff) - sfs_pkg::ACC_W'(pa2_ff)
            + RoundHalf;
      yfull = acc[sfs_pkg::ACC_W-1:sfs_pkg::FRAC_SHIFT];
      if (yfull > YMax) begin
         y0_in = YMax[sfs_pkg::SAMPLE_W-1:0];
      end else if (yfull < YMin) begin
         y0_in = YMin[sfs_pkg::SAMPLE_W-1:0];
      end else begin
         y0_in = yfull[sfs_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         k_ff        <= '0;
         hist_vld_ff <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         y_vld_ff    <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         k_ff        <= k_in;
         hist_vld_ff <= hist_vld_in;
         s1_v_ff     <= busy_ff;
         s2_v_ff     <= s1_v_ff;
         y_vld_ff    <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         hist_mem[s2_k_ff] <= {s2_y1_ff, y0_in};
      end
      rd_data_ff <= hist_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      rd_vld_ff   <= hist_vld_ff[k_ff];
      s1_k_ff     <= k_ff;
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= (k_ff == LastIdx);
      s1_coef_ff  <= coef_ff[k_ff];
      pb_ff       <= pb_in;
      pa1_ff      <= pa1_in;
      pa2_ff      <= pa2_in;
      s2_y1_ff    <= y1;
      s2_k_ff     <= s1_k_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      y_slot_ff   <= sfs_pkg::SLOT_W'(s2_k_ff);
      y_first_ff  <= s2_first_ff;
      y_last_ff   <= s2_last_ff;
      y0_ff       <= y0_in;
   end

   always_comb begin
      idle          = !busy_ff && !s1_v_ff && !s2_v_ff;
      ystream.valid = y_vld_ff;
      ystream.first = y_first_ff;
      ystream.last  = y_last_ff;
      ystream.slot  = y_slot_ff;
      ystream.y0    = y0_ff;
   end

endmodule

// ===== rtl/sfs_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formant mixer
// Weights and accumulates the filter outputs, scales the sum to the PCM range,
// truncates towards zero and saturates.
// ----------------------------------------------------------------------------
module sfs_mixer #(
   parameter int SAMPLE_BITS = sfs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sfs_pkg::ystream_type ystream,
   output sfs_pkg::mix_out_type mix_out
);

   localparam int ScaledW = sfs_pkg::MIX_W + SAMPLE_BITS;
   localparam int QW      = ScaledW - sfs_pkg::TRUNC_SHIFT;
   localparam logic signed [ScaledW-1:0] TruncBias =
      ScaledW'((longint'(1) << sfs_pkg::TRUNC_SHIFT) - 1);
   localparam logic signed [QW-1:0] PcmMax = QW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [QW-1:0] PcmMin = QW'(-(longint'(1) << (SAMPLE_BITS - 1)));

   logic                             w_vld_ff, w_first_ff, w_last_ff;
   logic signed [sfs_pkg::MIX_W-1:0] wprod_in, wprod_ff;
   logic signed [sfs_pkg::MIX_W-1:0] msum, mix_ff, t1_mix_ff;
   logic                             t1_vld_ff, t2_vld_ff, out_vld_ff;
   logic signed [ScaledW-1:0]        scaled_in, scaled_ff, adj;
   logic signed [QW-1:0]             q, sat;
   logic signed [sfs_pkg::PCM_EXT_W-1:0] ext;
   logic signed [sfs_pkg::PCM_W-1:0] pcm_in, pcm_ff;
   logic                             clip_in, clip_ff;

   always_comb begin
      wprod_in  = sfs_pkg::MIX_W'(sfs_pkg::mix_weight(ystream.slot))
                  * sfs_pkg::MIX_W'(ystream.y0);
      msum      = (w_first_ff ? '0 : mix_ff) + wprod_ff;
      scaled_in = (ScaledW'(t1_mix_ff) <<< (SAMPLE_BITS - 1)) - ScaledW'(t1_mix_ff);
   end

   always_comb begin
      adj     = scaled_ff + ((scaled_ff < 0) ? TruncBias : '0);
      q       = adj[ScaledW-1:sfs_pkg::TRUNC_SHIFT];
      clip_in = 1'b0;
      if (q > PcmMax) begin
         sat     = PcmMax;
         clip_in = 1'b1;
      end else if (q < PcmMin) begin
         sat     = PcmMin;
         clip_in = 1'b1;
      end else begin
         sat = q;
      end
      ext    = sfs_pkg::PCM_EXT_W'(sat);
      pcm_in = ext[sfs_pkg::PCM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff   <= 1'b0;
         t1_vld_ff  <= 1'b0;
         t2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         w_vld_ff   <= ystream.valid;
         t1_vld_ff  <= w_vld_ff && w_last_ff;
         t2_vld_ff  <= t1_vld_ff;
         out_vld_ff <= t2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_first_ff <= ystream.first;
      w_last_ff  <= ystream.last;
      wprod_ff   <= wprod_in;
      if (w_vld_ff) begin
         mix_ff <= msum;
      end
      t1_mix_ff <= msum;
      scaled_ff <= scaled_in;
      pcm_ff    <= pcm_in;
      clip_ff   <= clip_in;
   end

   always_comb begin
      mix_out.valid           = out_vld_ff;
      mix_out.data.pcm_sample = pcm_ff;
      mix_out.data.clipped    = clip_ff;
   end

endmodule

// ===== rtl/sfs_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response queue
// Small queue that holds finished samples until the consumer takes them.
// ----------------------------------------------------------------------------
module sfs_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  sfs_pkg::mix_out_type push,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output sfs_pkg::pcm_type     pop_data
);

   localparam int PtrW = $clog2(sfs_pkg::RSP_DEPTH);
   localparam int CntW = $clog2(sfs_pkg::RSP_DEPTH + 1);

   sfs_pkg::pcm_type entry_ff [sfs_pkg::RSP_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             pop;

   always_comb begin
      pop_valid = (count_ff != '0);
      pop_data  = entry_ff[rd_ptr_ff];
      pop       = pop_valid && pop_ready;
      wr_ptr_in = push.valid ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.valid) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ===== tb/sfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sawtooth formant synthesiser checker
// Watches the register port and both channels of the synthesiser. Every
// accepted request transaction is run through a bit-exact software copy of
// the oscillator, filter bank and mixer, and the predicted sample is queued.
// Every accepted response transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module sfs_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_clear_history,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [sfs_pkg::PCM_W-1:0]    rsp_pcm_sample,
   input  logic                                rsp_clipped,
   input  logic                                csr_write_enable,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output int                                  mismatches,
   output int                                  outstanding
);

   localparam int     NF         = sfs_pkg::NUM_FORMANTS_DEFAULT;
   localparam longint FULL_SCALE = (64'sd1 <<< (sfs_pkg::SAMPLE_BITS_DEFAULT - 1)) - 1;
   localparam longint Y_MAX      = (64'sd1 <<< (sfs_pkg::SAMPLE_W - 1)) - 1;
   localparam longint Y_MIN      = -(64'sd1 <<< (sfs_pkg::SAMPLE_W - 1));

   logic [sfs_pkg::PHASE_W-1:0]         step_size;
   logic [sfs_pkg::COEF_PACK_W-1:0]     coef_bank [NF];
   logic [sfs_pkg::PHASE_W-1:0]         osc_phase;
   logic signed [sfs_pkg::SAMPLE_W-1:0] saw_hist [2];
   logic signed [sfs_pkg::SAMPLE_W-1:0] band_hist [NF][2];
   sfs_pkg::pcm_type                    sample_queue [$];

   function automatic longint formant_gain(input int k);
      longint g;
      case (k)
         0: g = 65536;
         1: g = 39322;
         2: g = 19661;
         default: g = 0;
      endcase
      return g;
   endfunction

   function automatic void clear_filters();
      saw_hist[0] = '0;
      saw_hist[1] = '0;
      for (int k = 0; k < NF; k++) begin
         band_hist[k][0] = '0;
         band_hist[k][1] = '0;
      end
   endfunction

   function automatic sfs_pkg::pcm_type next_sample(input logic clear);
      longint                            saw, acc, y0, mix, scaled, pcm;
      logic signed [sfs_pkg::COEF_W-1:0] b0, a1, a2;
      sfs_pkg::pcm_type                  r;
      if (clear) begin
         clear_filters();
      end
      saw = longint'(osc_phase >> 9) - longint'(sfs_pkg::SAW_OFFSET);
      osc_phase = osc_phase + step_size;
      mix = 0;
      for (int k = 0; k < NF; k++) begin
         b0 = coef_bank[k][sfs_pkg::B0_LSB +: sfs_pkg::COEF_W];
         a1 = coef_bank[k][sfs_pkg::A1_LSB +: sfs_pkg::COEF_W];
         a2 = coef_bank[k][sfs_pkg::A2_LSB +: sfs_pkg::COEF_W];
         acc = b0 * saw - b0 * saw_hist[1] - a1 * band_hist[k][0] - a2 * band_hist[k][1];
         y0 = (acc + 64'sd32768) >>> sfs_pkg::FRAC_SHIFT;
         if (y0 > Y_MAX) begin
            y0 = Y_MAX;
         end
         if (y0 < Y_MIN) begin
            y0 = Y_MIN;
         end
         band_hist[k][1] = band_hist[k][0];
         band_hist[k][0] = sfs_pkg::SAMPLE_W'(y0);
         mix = mix + formant_gain(k) * y0;
      end
      saw_hist[1] = saw_hist[0];
      saw_hist[0] = sfs_pkg::SAMPLE_W'(saw);
      scaled = mix * FULL_SCALE;
      if (scaled >= 0) begin
         pcm = scaled >>> sfs_pkg::TRUNC_SHIFT;
      end else begin
         pcm = -((-scaled) >>> sfs_pkg::TRUNC_SHIFT);
      end
      r.clipped = 1'b0;
      if (pcm > FULL_SCALE) begin
         pcm = FULL_SCALE;
         r.clipped = 1'b1;
      end
      if (pcm < -FULL_SCALE - 1) begin
         pcm = -FULL_SCALE - 1;
         r.clipped = 1'b1;
      end
      r.pcm_sample = sfs_pkg::PCM_W'(pcm);
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      sfs_pkg::pcm_type want;
      if (reset) begin
         step_size = sfs_pkg::PHASE_INCREMENT_RESET;
         for (int k = 0; k < NF; k++) begin
            coef_bank[k] = '0;
         end
         osc_phase = '0;
         clear_filters();
         sample_queue.delete();
         mismatches = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == sfs_pkg::CSR_PHASE_INCREMENT) begin
               step_size = csr_write_data[sfs_pkg::PHASE_W-1:0];
            end else if (int'(csr_index - sfs_pkg::CSR_FORMANT_BASE) < NF) begin
               coef_bank[csr_index - sfs_pkg::CSR_FORMANT_BASE] =
                  csr_write_data[sfs_pkg::COEF_PACK_W-1:0];
            end
         end
         if (req_valid && req_ready) begin
            sample_queue.push_back(next_sample(req_clear_history));
         end
         if (rsp_valid && rsp_ready) begin
            if (sample_queue.size() == 0) begin
               mismatches++;
               $display("%0t: response transaction with none expected, pcm_sample %0d clipped %0b",
                        $time, rsp_pcm_sample, rsp_clipped);
            end else begin
               want = sample_queue.pop_front();
               if (rsp_pcm_sample !== want.pcm_sample) begin
                  mismatches++;
                  $display("%0t: pcm_sample expected %0d, actual %0d",
                           $time, want.pcm_sample, rsp_pcm_sample);
               end
               if (rsp_clipped !== want.clipped) begin
                  mismatches++;
                  $display("%0t: clipped expected %0b, actual %0b",
                           $time, want.clipped, rsp_clipped);
               end
            end
         end
      end
      outstanding <= sample_queue.size();
   end

endmodule

// ===== tb/tb_sawtooth_formant_synth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sawtooth formant synthesiser testbench
// Drives request transactions through a series of oscillator and filter
// settings, from hand-picked extremes to random coefficients, with random
// idling on both channels and one long response stall. The checker beside
// the block predicts every sample and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_sawtooth_formant_synth;

   localparam int LATENCY         = sfs_pkg::NUM_FORMANTS_DEFAULT + 8;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                                 clock             = 1'b0;
   logic                                 reset             = 1'b1;
   logic                                 req_valid         = 1'b0;
   logic                                 req_clear_history = 1'b0;
   logic                                 rsp_ready         = 1'b0;
   logic                                 csr_write_enable  = 1'b0;
   logic [sfs_pkg::CSR_INDEX_W-1:0]      csr_index         = '0;
   logic [sfs_pkg::CSR_DATA_W-1:0]       csr_write_data    = '0;
   logic                                 req_ready;
   logic                                 rsp_valid;
   logic signed [sfs_pkg::PCM_W-1:0]     rsp_pcm_sample;
   logic                                 rsp_clipped;
   int                                   mismatches;
   int                                   outstanding;
   bit                                   quiet        = 1'b0;
   bit                                   hold_request = 1'b0;
   logic [sfs_pkg::COEF_PACK_W-1:0]      vowel [3];

   sawtooth_formant_synth dut (.*);

   sfs_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("sawtooth_formant_synth test failed");
      $finish;
   end

   initial begin : receiver
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   function automatic logic [sfs_pkg::COEF_PACK_W-1:0] pack_coefs(input int b0, input int a1,
                                                                  input int a2);
      return {sfs_pkg::COEF_W'(a2), sfs_pkg::COEF_W'(a1), sfs_pkg::COEF_W'(b0)};
   endfunction

   function automatic int extreme_coef();
      int v;
      case ($urandom_range(0, 4))
         0: v = -131072;
         1: v = 131071;
         2: v = 0;
         3: v = -1;
         default: v = 1;
      endcase
      return v;
   endfunction

   function automatic logic [sfs_pkg::COEF_PACK_W-1:0] pick_coefs();
      logic [sfs_pkg::COEF_PACK_W-1:0] c;
      case ($urandom_range(0, 3))
         0: c = sfs_pkg::COEF_PACK_W'({$urandom(), $urandom()});
         1: c = pack_coefs($urandom_range(0, 4000), -int'($urandom_range(100000, 131072)),
                           $urandom_range(55000, 65535));
         2: c = pack_coefs(extreme_coef(), extreme_coef(), extreme_coef());
         default: c = pack_coefs(int'($urandom_range(0, 262143)) - 131072, 0, 0);
      endcase
      return c;
   endfunction

   function automatic logic [sfs_pkg::PHASE_W-1:0] pick_increment();
      logic [sfs_pkg::PHASE_W-1:0] inc;
      case ($urandom_range(0, 5))
         0: inc = '0;
         1: inc = '1;
         2: inc = 32'h8000_0000;
         3: inc = $urandom_range(0, 32'h00FF_FFFF);
         default: inc = $urandom();
      endcase
      return inc;
   endfunction

   task automatic send_tick(input logic clear);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_clear_history <= clear;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         send_tick($urandom_range(0, 15) == 0);
      end
   endtask

   task automatic drain();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (outstanding != 0 && guard < 5000);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic load_settings(input logic [sfs_pkg::PHASE_W-1:0] inc,
                                input logic [sfs_pkg::COEF_PACK_W-1:0] f1,
                                input logic [sfs_pkg::COEF_PACK_W-1:0] f2,
                                input logic [sfs_pkg::COEF_PACK_W-1:0] f3);
      logic [sfs_pkg::COEF_PACK_W-1:0] coefs [3];
      coefs = '{f1, f2, f3};
      csr_write_enable <= 1'b1;
      csr_index        <= sfs_pkg::CSR_PHASE_INCREMENT;
      csr_write_data   <= sfs_pkg::CSR_DATA_W'(inc);
      @(posedge clock);
      for (int k = 0; k < 3; k++) begin
         csr_index      <= sfs_pkg::CSR_FORMANT_BASE + sfs_pkg::CSR_INDEX_W'(k);
         csr_write_data <= coefs[k];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      vowel[0] = pack_coefs(325, -129126, 64886);
      vowel[1] = pack_coefs(562, -127990, 64413);
      vowel[2] = pack_coefs(1165, -120011, 63206);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      drain();

      load_settings('1, pack_coefs(131071, 0, 0), pack_coefs(-131072, 0, 0),
                    pack_coefs(131071, -131072, 131071));
      repeat (6) send_tick(1'b0);
      send_tick(1'b1);
      drain();

      load_settings(32'h8000_0000, pack_coefs(-131072, 131071, -131072), '1,
                    pack_coefs(1, -1, 0));
      repeat (4) send_tick(1'b0);
      send_tick(1'b1);
      drain();

      load_settings('0, vowel[0], vowel[1], vowel[2]);
      repeat (3) send_tick(1'b0);
      drain();

      load_settings(sfs_pkg::PHASE_INCREMENT_RESET, vowel[0], vowel[1], vowel[2]);
      hold_request = 1'b1;
      send_random_ticks(200);

      for (int p = 0; p < 6; p++) begin
         drain();
         load_settings(pick_increment(), pick_coefs(), pick_coefs(), pick_coefs());
         send_random_ticks(160);
      end

      drain();
      quiet = 1'b1;
      load_settings(sfs_pkg::PHASE_INCREMENT_RESET, vowel[0], vowel[1], vowel[2]);
      send_random_ticks(150);
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("sawtooth_formant_synth test passed");
      end else begin
         $display("sawtooth_formant_synth test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sfs_pkg.sv
rtl/sfs_formant_engine.sv
rtl/sfs_mixer.sv
rtl/sfs_rsp_fifo.sv
rtl/sawtooth_formant_synth.sv
tb/sfs_checker.sv
tb/tb_sawtooth_formant_synth.sv
